[sv/mps_pkg.sv]
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types and constants of the metaball pixel shader: register codes,
// field widths, ball motion constants and the region color table.
// ----------------------------------------------------------------------------
package mps_pkg;

  // Default build options
  localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF       = 12;

  // Port field widths
  localparam int unsigned PIXEL_W    = 12;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LEVEL_W    = 9;
  localparam int unsigned REGION_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;

  // Configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_FRAME_TIME   = 2'd2
  } cfg_idx_e;

  // Pixel classification
  typedef enum logic [REGION_W-1:0] {
    REGION_BG   = 2'd0,
    REGION_CORE = 2'd1,
    REGION_RIM  = 2'd2
  } region_e;

  // uv is signed Q3.16
  localparam int unsigned UV_W      = 20;
  localparam int unsigned UV_FRAC_W = 16;

  // Ball centres: six coordinates, each a sine of a phase ramp
  localparam int unsigned BALL_COORDS  = 6;
  localparam int unsigned BALL_SEL_W   = 3;
  localparam int unsigned BALL_W       = 17;
  localparam int unsigned FACTOR_W     = 38;
  localparam int unsigned FACTOR_SPLIT = 19;
  localparam int unsigned SINE_W       = 17;
  localparam logic [TIME_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [FACTOR_W-1:0] PHASE_FACTOR [BALL_COORDS] = '{
    38'd65622266455, 38'd43748177637, 38'd87496355274,
    38'd78746719746, 38'd135619350674, 38'd118120079620
  };
  localparam logic PHASE_IS_COS [BALL_COORDS] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
  localparam logic [2:0] BALL_TENTHS [BALL_COORDS] = '{3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6};

  // floor(x / 10) as (x * RECIP_TEN) >> RECIP_SHIFT, exact below 2^19
  localparam int unsigned SCALED_W    = 19;
  localparam int unsigned RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 20'd838861;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned TENTH_W     = 16;

  // Terms in Q4.12, field in Q6.12
  localparam int unsigned TERM_W    = 16;
  localparam int unsigned FIELD_W   = 18;
  localparam logic [FIELD_W-1:0] FIELD_ONE     = 18'd4096;
  localparam logic [FIELD_W-1:0] FIELD_RIM_TOP = 18'd4915;

  // r, g, b, a per region
  localparam logic [LEVEL_W-1:0] COLOR_LUT [3][4] = '{
    '{9'd0,   9'd13,  9'd51,  9'd256},
    '{9'd41,  9'd166, 9'd215, 9'd256},
    '{9'd246, 9'd371, 9'd420, 9'd461}
  };

endpackage

[sv/metaball_pixel_shader.sv]
// ----------------------------------------------------------------------------
// metaball_pixel_shader
// Colors one pixel per item: centres and scales the coordinate, sums the
// 0.1/distance field of three moving balls and picks a region color.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata: pixel_x, pixel_y
// m_axis    out        tdata: red, green, blue, alpha levels; tuser: region
// cfg       in         we, index, data: frame_width, frame_height, frame_time
//
// One item per cycle while the output takes results; each item passes the uv
// divider, the square root, the field divider and the stages around them.
// The whole pipeline advances together and halts while a result at the
// output is not taken; valid bits travel with the items.
// Ball centres come from a free-running sequencer that refreshes all six
// coordinates in turn after a frame_time write.
// Reset clears control state and loads the register defaults; no sweep.
// ----------------------------------------------------------------------------
module metaball_pixel_shader
  import mps_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int unsigned COORD_BITS       = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pixel_x, pixel_y
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // red, green, blue, alpha, zero pad
  output logic [REGION_W-1:0]   m_axis_tuser,   // region
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Widths
  localparam int unsigned P_W      = (COORD_BITS < PIXEL_W) ? COORD_BITS : PIXEL_W;
  localparam int unsigned MAG_W    = DIM_W;
  localparam int unsigned UNUM_W   = MAG_W + UV_FRAC_W;
  localparam int unsigned UDEN_W   = DIM_W + 1;
  localparam int unsigned UV_LAT   = UV_W + 1;
  localparam int unsigned DX_W     = UV_W + 1;
  localparam int unsigned AX_W     = UV_W;
  localparam int unsigned SQ_W     = 2 * AX_W;
  localparam int unsigned VAL_W    = SQ_W + 2;
  localparam int unsigned RT_W     = VAL_W / 2;
  localparam int unsigned TNUM_W   = 29;
  localparam int unsigned TDEN_W   = RT_W + 4;
  localparam int unsigned LAT      = 1 + UV_LAT + 4 + RT_W + 1 + (TERM_W + 1) + 2;
  localparam int unsigned IDX_W    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned IDXP_W   = 30 + IDX_W;
  localparam int unsigned PROD_W   = 48;
  localparam int unsigned PHI_W    = PROD_W - FACTOR_SPLIT;
  localparam int unsigned RPROD_W  = SCALED_W + RECIP_W;
  localparam logic [IDX_W-1:0]  DEPTH_IDX   = IDX_W'(SINE_TABLE_DEPTH);
  localparam logic [UV_W-1:0]   UV_NEG_MAG  = UV_W'(1) << (UV_W - 1);
  localparam logic [UV_W-1:0]   UV_POS_MAX  = UV_NEG_MAG - UV_W'(1);
  localparam logic [TNUM_W-1:0] TERM_ONE    = TNUM_W'(1) << 28;

  // Quarter-wave sine table, built at elaboration
  typedef logic [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH+1];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         rom;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   v;
    longint            sum;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 6;   sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 20;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 42;  sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 72;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 110; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 156; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 210; sum = sum - $signed(term);
      v = (sum < 0) ? 64'd0 : ((64'(sum) + 64'd8192) >> 14);
      if (v > 64'd65536) begin
        v = 64'd65536;
      end
      rom[i] = SINE_W'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Saturate a divided magnitude into signed uv
  function automatic logic signed [UV_W-1:0] sat_uv(logic [UV_W-1:0] quo, logic ovf,
                                                    logic neg);
    logic [UV_W-1:0] mag;
    if (neg) begin
      mag = (ovf || (quo > UV_NEG_MAG)) ? UV_NEG_MAG : quo;
      return $signed(UV_W'(0) - mag);
    end
    mag = (ovf || (quo > UV_POS_MAX)) ? UV_POS_MAX : quo;
    return $signed(mag);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;
  logic [TIME_W-1:0] time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(640);
      height_q <= DIM_W'(480);
      time_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_TIME:   time_q   <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Ball centre sequencer: one coordinate enters per cycle, free running
  // --------------------------------------------------------------------------
  logic [BALL_SEL_W-1:0]  seq_q;
  logic [PROD_W-1:0]      prod_lo_q;
  logic [PHI_W-1:0]       prod_hi_q;
  logic [BALL_SEL_W-1:0]  k1_q, k2_q, k3_q, k4_q, k5_q, k6_q;
  logic [TIME_W-1:0]      phase_q;
  logic [IDX_W-1:0]       idx_q;
  logic [1:0]             quad_q;
  logic [SINE_W-1:0]      rom_q;
  logic                   neg4_q, neg5_q, neg6_q;
  logic [SCALED_W-1:0]    scaled_q;
  logic [TENTH_W-1:0]     tenth_q;
  logic signed [BALL_W-1:0] ball_q [BALL_COORDS];

  logic [PROD_W-1:0]      phase_sum_w;
  logic [IDXP_W-1:0]      idx_prod_w;
  logic [IDX_W-1:0]       idx_lim_w;
  logic [IDX_W-1:0]       idx_rd_w;
  logic [RPROD_W-1:0]     recip_prod_w;

  assign phase_sum_w  = prod_lo_q + {prod_hi_q, FACTOR_SPLIT'(0)};
  assign idx_prod_w   = IDXP_W'(phase_q[29:0]) * IDXP_W'(SINE_TABLE_DEPTH)
                      + (IDXP_W'(1) << 29);
  assign idx_lim_w    = (idx_q > DEPTH_IDX) ? DEPTH_IDX : idx_q;
  assign idx_rd_w     = quad_q[0] ? (DEPTH_IDX - idx_lim_w) : idx_lim_w;
  assign recip_prod_w = RPROD_W'(scaled_q) * RPROD_W'(RECIP_TEN);

  // Step through the six coordinates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
    end else if (seq_q == BALL_SEL_W'(BALL_COORDS - 1)) begin
      seq_q <= '0;
    end else begin
      seq_q <= seq_q + 1'b1;
    end
  end

  // Phase, table lookup, scale by tenths, store
  always_ff @(posedge clk_i) begin
    prod_lo_q <= PROD_W'(time_q) * PROD_W'(PHASE_FACTOR[seq_q][FACTOR_SPLIT-1:0]);
    prod_hi_q <= PHI_W'(time_q) * PHI_W'(PHASE_FACTOR[seq_q][FACTOR_W-1:FACTOR_SPLIT]);
    k1_q      <= seq_q;

    phase_q   <= phase_sum_w[PROD_W-1:16] + (PHASE_IS_COS[k1_q] ? QUARTER_TURN : '0);
    k2_q      <= k1_q;

    idx_q     <= idx_prod_w[30 +: IDX_W];
    quad_q    <= phase_q[31:30];
    k3_q      <= k2_q;

    rom_q     <= SINE_ROM[idx_rd_w];
    neg4_q    <= quad_q[1];
    k4_q      <= k3_q;

    scaled_q  <= SCALED_W'(rom_q) * SCALED_W'(BALL_TENTHS[k4_q]) + SCALED_W'(5);
    neg5_q    <= neg4_q;
    k5_q      <= k4_q;

    tenth_q   <= recip_prod_w[RECIP_SHIFT +: TENTH_W];
    neg6_q    <= neg5_q;
    k6_q      <= k5_q;

    ball_q[k6_q] <= neg6_q ? -$signed({1'b0, tenth_q}) : $signed({1'b0, tenth_q});
  end

  // --------------------------------------------------------------------------
  // Pixel pipeline control
  // --------------------------------------------------------------------------
  logic           en_w;
  logic [LAT-1:0] valid_q;

  assign en_w          = !valid_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en_w;
  assign m_axis_tvalid = valid_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_w) begin
      valid_q <= {valid_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: centre the coordinate
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]  dbl_x_w, dbl_y_w;
  logic [DIM_W-1:0]  h_w;
  logic [MAG_W-1:0]  mag_x_q, mag_y_q;
  logic [UDEN_W-1:0] uden_q;
  logic [UV_LAT:0]   negx_q, negy_q;

  assign dbl_x_w = DIM_W'({s_axis_tdata[P_W-1:0], 1'b0});
  assign dbl_y_w = DIM_W'({s_axis_tdata[PIXEL_W +: P_W], 1'b0});
  assign h_w     = (height_q == '0) ? DIM_W'(1) : height_q;

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      mag_x_q <= (dbl_x_w >= width_q) ? (dbl_x_w - width_q) : (width_q - dbl_x_w);
      mag_y_q <= (dbl_y_w >= height_q) ? (dbl_y_w - height_q) : (height_q - dbl_y_w);
      uden_q  <= {h_w, 1'b0};
      negx_q  <= {negx_q[UV_LAT-1:0], (dbl_x_w < width_q)};
      negy_q  <= {negy_q[UV_LAT-1:0], (dbl_y_w < height_q)};
    end
  end

  // Scale by the frame height
  logic [UV_W-1:0] uquo_x_w, uquo_y_w;
  logic            uovf_x_w, uovf_y_w;

  mps_div #(.NUM_W(UNUM_W), .DEN_W(UDEN_W), .QUO_W(UV_W)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en_w),
    .num_i ({mag_x_q, UV_FRAC_W'(0)}),
    .den_i (uden_q),
    .quo_o (uquo_x_w),
    .ovf_o (uovf_x_w)
  );

  mps_div #(.NUM_W(UNUM_W), .DEN_W(UDEN_W), .QUO_W(UV_W)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en_w),
    .num_i ({mag_y_q, UV_FRAC_W'(0)}),
    .den_i (uden_q),
    .quo_o (uquo_y_w),
    .ovf_o (uovf_y_w)
  );

  // Stage B: saturate uv
  logic signed [UV_W-1:0] ux_q, uy_q;

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      ux_q <= sat_uv(uquo_x_w, uovf_x_w, negx_q[UV_LAT]);
      uy_q <= sat_uv(uquo_y_w, uovf_y_w, negy_q[UV_LAT]);
    end
  end

  // --------------------------------------------------------------------------
  // Per ball: distance, then 0.1 / distance
  // --------------------------------------------------------------------------
  logic [AX_W-1:0]    ax_q   [3];
  logic [AX_W-1:0]    ay_q   [3];
  logic [SQ_W-1:0]    sqx_q  [3];
  logic [SQ_W-1:0]    sqy_q  [3];
  logic [VAL_W-1:0]   dsq_q  [3];
  logic [RT_W-1:0]    dist_w [3];
  logic [TNUM_W-1:0]  tnum_q [3];
  logic [TDEN_W-1:0]  tden_q [3];
  logic [TERM_W-1:0]  tquo_w [3];
  logic               tovf_w [3];
  logic [TERM_W-1:0]  term_w [3];

  for (genvar b = 0; b < 3; b++) begin : g_ball
    logic signed [DX_W-1:0] dx_w, dy_w;

    assign dx_w = DX_W'(ux_q) - DX_W'(ball_q[2*b]);
    assign dy_w = DX_W'(uy_q) - DX_W'(ball_q[2*b+1]);

    // Stages C, D, E: magnitude, square, sum
    always_ff @(posedge clk_i) begin
      if (en_w) begin
        ax_q[b]  <= dx_w[DX_W-1] ? AX_W'(-dx_w) : AX_W'(dx_w);
        ay_q[b]  <= dy_w[DX_W-1] ? AX_W'(-dy_w) : AX_W'(dy_w);
        sqx_q[b] <= SQ_W'(ax_q[b]) * SQ_W'(ax_q[b]);
        sqy_q[b] <= SQ_W'(ay_q[b]) * SQ_W'(ay_q[b]);
        dsq_q[b] <= VAL_W'(sqx_q[b]) + VAL_W'(sqy_q[b]);
      end
    end

    mps_sqrt #(.VAL_W(VAL_W)) u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en_w),
      .val_i  (dsq_q[b]),
      .root_o (dist_w[b])
    );

    // Stage F: (2^28 + 5d) / (10d); zero distance overflows to the maximum
    always_ff @(posedge clk_i) begin
      if (en_w) begin
        tnum_q[b] <= TERM_ONE + TNUM_W'(dist_w[b]) * TNUM_W'(5);
        tden_q[b] <= TDEN_W'(dist_w[b]) * TDEN_W'(10);
      end
    end

    mps_div #(.NUM_W(TNUM_W), .DEN_W(TDEN_W), .QUO_W(TERM_W)) u_div_term (
      .clk_i (clk_i),
      .en_i  (en_w),
      .num_i (tnum_q[b]),
      .den_i (tden_q[b]),
      .quo_o (tquo_w[b]),
      .ovf_o (tovf_w[b])
    );

    assign term_w[b] = tovf_w[b] ? '1 : tquo_w[b];
  end

  // Stage G: sum the field; clamping each term keeps every threshold result
  logic [FIELD_W-1:0] field_q;

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      field_q <= FIELD_W'(term_w[0]) + FIELD_W'(term_w[1]) + FIELD_W'(term_w[2]);
    end
  end

  // Stage H: classify and look up the color
  region_e            region_d;
  region_e            region_q;
  logic [LEVEL_W-1:0] red_q, green_q, blue_q, alpha_q;

  always_comb begin
    if (field_q <= FIELD_ONE) begin
      region_d = REGION_BG;
    end else if (field_q <= FIELD_RIM_TOP) begin
      region_d = REGION_RIM;
    end else begin
      region_d = REGION_CORE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      region_q <= region_d;
      red_q    <= COLOR_LUT[region_d][0];
      green_q  <= COLOR_LUT[region_d][1];
      blue_q   <= COLOR_LUT[region_d][2];
      alpha_q  <= COLOR_LUT[region_d][3];
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W - 4 * LEVEL_W)'(0), alpha_q, blue_q, green_q, red_q};
  assign m_axis_tuser = region_q;

endmodule

[sv/mps_div.sv]
// ----------------------------------------------------------------------------
// mps_div
// Pipelined restoring divider, one quotient bit per stage. Flags a quotient
// that does not fit in QUO_W bits.
// ----------------------------------------------------------------------------
module mps_div #(
  parameter int unsigned NUM_W = 29,
  parameter int unsigned DEN_W = 14,
  parameter int unsigned QUO_W = 20
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o
);

  localparam int unsigned REM_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

  logic [REM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic             ovf_q [QUO_W+1];

  logic [REM_W-1:0] num_ext_w;
  logic [REM_W-1:0] den_top_w;

  assign num_ext_w = REM_W'(num_i);
  assign den_top_w = REM_W'(den_i) << QUO_W;

  // Load and check the quotient range
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_ext_w;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (num_ext_w >= den_top_w);
    end
  end

  // One trial subtraction per stage, most significant bit first
  for (genvar j = 1; j <= QUO_W; j++) begin : g_step
    localparam int unsigned STEP_POS = QUO_W - j;
    logic [REM_W-1:0] sub_w;
    logic             fit_w;

    assign sub_w = REM_W'(den_q[j-1]) << STEP_POS;
    assign fit_w = (rem_q[j-1] >= sub_w);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j] <= quo_q[j-1] | (fit_w ? (QUO_W'(1) << STEP_POS) : QUO_W'(0));
        ovf_q[j] <= ovf_q[j-1];
      end
    end

    if (j < QUO_W) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= fit_w ? (rem_q[j-1] - sub_w) : rem_q[j-1];
          den_q[j] <= den_q[j-1];
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

[sv/mps_sqrt.sv]
// ----------------------------------------------------------------------------
// mps_sqrt
// Pipelined integer square root, floor(sqrt(value)), one root bit per stage.
// ----------------------------------------------------------------------------
module mps_sqrt #(
  parameter int unsigned VAL_W = 42
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [VAL_W-1:0]     val_i,
  output logic [VAL_W/2-1:0]   root_o
);

  localparam int unsigned RT_W = VAL_W / 2;

  logic [VAL_W-1:0] v_q [RT_W];
  logic [VAL_W-1:0] r_q [RT_W];

  // Each stage tests one power of four, largest first
  for (genvar j = 0; j < RT_W; j++) begin : g_step
    localparam logic [VAL_W:0] STEP_ONE = (VAL_W+1)'(1) << (VAL_W - 2 - 2 * j);
    logic [VAL_W-1:0] v_w;
    logic [VAL_W-1:0] r_w;
    logic [VAL_W:0]   try_w;
    logic             fit_w;

    if (j == 0) begin : g_first
      assign v_w = val_i;
      assign r_w = '0;
    end else begin : g_next
      assign v_w = v_q[j-1];
      assign r_w = r_q[j-1];
    end

    assign try_w = {1'b0, r_w} + STEP_ONE;
    assign fit_w = ({1'b0, v_w} >= try_w);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[j] <= fit_w ? (v_w - try_w[VAL_W-1:0]) : v_w;
        r_q[j] <= fit_w ? ((r_w >> 1) + STEP_ONE[VAL_W-1:0]) : (r_w >> 1);
      end
    end
  end

  assign root_o = r_q[RT_W-1][RT_W-1:0];

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for metaball_pixel_shader: pixel items go in through
// the input stream, a local color predictor computes each expected pixel and
// every output item is compared field by field. Frame registers are changed
// between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb;
  import mps_pkg::*;

  localparam int unsigned DEPTH      = SINE_TABLE_DEPTH_DEF;
  localparam int unsigned PIPE_DRAIN = 90;   // pipeline is 67 deep
  localparam int unsigned BALL_SETTLE = 20;  // wait for the balls to refresh
  localparam longint unsigned HALF_PI = 64'd1686629713;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] alpha;
    region_e            region;
  } pixel_color_t;

  typedef struct {
    int unsigned x;
    int unsigned y;
    bit          known;
    region_e     region;
  } pixel_row_t;

  typedef struct {
    int unsigned      width;
    int unsigned      height;
    logic [TIME_W-1:0] ftime;
    bit               random_time;
    bit               pressure;
    bit               quiet;
  } frame_setup_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // pixel_x, pixel_y
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // red, green, blue, alpha, zero pad
  logic [REGION_W-1:0]   m_axis_tuser;        // region
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  metaball_pixel_shader dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // Local copy of the frame registers and the quarter-wave table
  longint unsigned frame_w = 640;
  longint unsigned frame_h = 480;
  longint unsigned frame_t = 0;
  longint unsigned quarter_sine [DEPTH+1];

  pixel_color_t pending_colors [$];
  int  error_count = 0;
  bit  quiet_mode = 1'b0;
  bit  pressure_req = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void build_quarter_sine();
    longint unsigned x, x2, term, v;
    longint sum;
    for (int i = 0; i <= DEPTH; i++) begin
      x = (longint'(i) * HALF_PI) / DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (longint'(sum) + 8192) >> 14;
      if (v > 65536) v = 65536;
      quarter_sine[i] = v;
    end
  endfunction

  // Ball coordinate k: scaled sine (or cosine) of its phase ramp
  function automatic longint ball_coord(input int k);
    logic [31:0] ph;
    longint unsigned idx, m, r;
    longint v;
    ph = 32'((frame_t * longint'(PHASE_FACTOR[k])) >> 16);
    if (PHASE_IS_COS[k]) ph = ph + QUARTER_TURN;
    idx = ((longint'(ph[29:0]) * DEPTH) + (64'd1 << 29)) >> 30;
    if (idx > DEPTH) idx = DEPTH;
    if (ph[30]) idx = DEPTH - idx;
    v = longint'(quarter_sine[idx]);
    m = v;
    r = (m * BALL_TENTHS[k] + 5) / 10;
    return ph[31] ? -longint'(r) : longint'(r);
  endfunction

  // Centered, height-scaled coordinate in Q3.16, saturated
  function automatic longint center_uv(input longint unsigned p, input longint unsigned span);
    longint num;
    longint unsigned mag, q, h;
    h = (frame_h == 0) ? 1 : frame_h;
    num = 2 * longint'(p) - longint'(span);
    mag = (num < 0) ? -num : num;
    q = (mag << 16) / (2 * h);
    if (num < 0) begin
      if (q > 524288) q = 524288;
      return -longint'(q);
    end
    if (q > 524287) q = 524287;
    return longint'(q);
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic pixel_color_t predict_color(input int unsigned px, input int unsigned py);
    longint ux, uy, dx, dy;
    longint unsigned d, field;
    longint bc [BALL_COORDS];
    pixel_color_t c;
    ux = center_uv(px % (1 << COORD_BITS_DEF), frame_w);
    uy = center_uv(py % (1 << COORD_BITS_DEF), frame_h);
    for (int k = 0; k < BALL_COORDS; k++) bc[k] = ball_coord(k);
    field = 0;
    for (int b = 0; b < 3; b++) begin
      dx = ux - bc[2 * b];
      dy = uy - bc[2 * b + 1];
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      d = floor_sqrt(longint'(dx * dx) + longint'(dy * dy));
      if (d == 0) field += 65535;
      else field += ((64'd1 << 28) + 5 * d) / (10 * d);
    end
    if (field > 65535) field = 65535;
    if (field <= 4096) c.region = REGION_BG;
    else if (field <= 4915) c.region = REGION_RIM;
    else c.region = REGION_CORE;
    c.red   = COLOR_LUT[c.region][0];
    c.green = COLOR_LUT[c.region][1];
    c.blue  = COLOR_LUT[c.region][2];
    c.alpha = COLOR_LUT[c.region][3];
    return c;
  endfunction

  // Pulse the write enable for one cycle, then idle before returning
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  frame_w = value & 32'h1FFF;
      CFG_FRAME_HEIGHT: frame_h = value & 32'h1FFF;
      CFG_FRAME_TIME:   frame_t = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Offer one pixel item, after a random gap unless quiet; else valid stays high straight into the next item
  task automatic send_pixel(input int unsigned px, input int unsigned py);
    int unsigned gap;
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {py[PIXEL_W-1:0], px[PIXEL_W-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_colors.push_back(predict_color(px, py));
    @(negedge clk_i);
  endtask

  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (pending_colors.size() != 0) @(negedge clk_i);
    repeat (PIPE_DRAIN) @(negedge clk_i);
  endtask

  // Receiver: random stall bursts plus one long hold-off on request
  int unsigned stall_left = 0;
  bit          pressure_done = 1'b0;
  always @(negedge clk_i) begin
    if (pressure_req && !pressure_done) begin
      pressure_done <= 1'b1;
      stall_left <= 250;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each output item with the oldest expectation
  always @(posedge clk_i) begin
    pixel_color_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_colors.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = pending_colors.pop_front();
        if (m_axis_tdata[8:0] !== want.red)
          report_mismatch("red", m_axis_tdata[8:0], want.red);
        if (m_axis_tdata[17:9] !== want.green)
          report_mismatch("green", m_axis_tdata[17:9], want.green);
        if (m_axis_tdata[26:18] !== want.blue)
          report_mismatch("blue", m_axis_tdata[26:18], want.blue);
        if (m_axis_tdata[35:27] !== want.alpha)
          report_mismatch("alpha", m_axis_tdata[35:27], want.alpha);
        if (m_axis_tdata[OUT_DATA_W-1:36] !== '0)
          report_mismatch("pad", m_axis_tdata[OUT_DATA_W-1:36], 0);
        if (m_axis_tuser !== want.region)
          report_mismatch("region", m_axis_tuser, want.region);
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  pixel_row_t   directed [13] = '{
    '{0, 0, 1'b0, REGION_BG},
    '{4095, 4095, 1'b1, REGION_BG},      // far corner: field tiny
    '{4095, 0, 1'b0, REGION_BG},
    '{0, 4095, 1'b0, REGION_BG},
    '{320, 240, 1'b0, REGION_BG},        // frame center
    '{320, 480, 1'b1, REGION_CORE},      // exactly on the second ball
    '{576, 240, 1'b0, REGION_BG},        // between the first and third balls
    '{464, 240, 1'b0, REGION_BG},
    '{2730, 1365, 1'b0, REGION_BG},      // alternating bit patterns
    '{1365, 2730, 1'b0, REGION_BG},
    '{330, 470, 1'b0, REGION_BG},
    '{300, 300, 1'b0, REGION_BG},
    '{639, 479, 1'b0, REGION_BG}
  };

  frame_setup_t phases [6] = '{
    '{64, 48, 32'd0, 1'b1, 1'b0, 1'b0},
    '{1, 1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},     // smallest frame, time wrap
    '{4096, 4096, 32'd0, 1'b1, 1'b0, 1'b0},       // largest frame
    '{8191, 0, 32'd0, 1'b1, 1'b0, 1'b0},          // zero height, wide span
    '{32, 24, 32'd0, 1'b1, 1'b1, 1'b0},
    '{200, 150, 32'd0, 1'b1, 1'b0, 1'b1}
  };

  initial begin
    pixel_color_t want;
    int unsigned px, py, wlim, hlim;
    build_quarter_sine();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed pixels at reset settings
    foreach (directed[i]) begin
      if (directed[i].known) begin
        want.region = directed[i].region;
        want.red    = COLOR_LUT[want.region][0];
        want.green  = COLOR_LUT[want.region][1];
        want.blue   = COLOR_LUT[want.region][2];
        want.alpha  = COLOR_LUT[want.region][3];
        if (predict_color(directed[i].x, directed[i].y) != want)
          report_mismatch("predictor sanity", i, 0);
      end
      send_pixel(directed[i].x, directed[i].y);
    end

    // Random phases with fresh frame settings
    foreach (phases[p]) begin
      drain_pipe();
      if (p == 3) write_reg(cfg_idx_e'(2'd3), $urandom());   // unmapped index
      write_reg(CFG_FRAME_WIDTH, phases[p].width);
      write_reg(CFG_FRAME_HEIGHT, phases[p].height);
      write_reg(CFG_FRAME_TIME,
                phases[p].random_time ? $urandom() : phases[p].ftime);
      repeat (BALL_SETTLE) @(negedge clk_i);
      quiet_mode = phases[p].quiet;
      wlim = (frame_w == 0) ? 0 : ((frame_w > 4096) ? 4095 : frame_w - 1);
      hlim = (frame_h == 0) ? 0 : ((frame_h > 4096) ? 4095 : frame_h - 1);
      for (int n = 0; n < 95; n++) begin
        if (phases[p].pressure && n == 10) pressure_req = 1'b1;
        if ($urandom_range(0, 4) == 0) begin
          px = $urandom_range(0, 4095);
          py = $urandom_range(0, 4095);
        end else begin
          px = $urandom_range(0, wlim);
          py = $urandom_range(0, hlim);
        end
        send_pixel(px, py);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_colors.size() != 0) @(negedge clk_i);
    repeat (PIPE_DRAIN) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
